>>> rtl/prrs_pkg.sv
// Package for the priority round-robin scheduler.
// Field widths, codes, controller states and controller command/status types.
// No dependencies.
package prrs_pkg;

   localparam int IdWidth      = 3;
   localparam int BurstWidth   = 8;
   localparam int QuantumWidth = 8;
   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 3;

   localparam logic [QuantumWidth-1:0] QuantumReset = 8'd2;

   // register index, taken from paddr[2]
   localparam logic RegQuantum = 1'b0;

   // request codes
   localparam logic ReqArrive   = 1'b0;
   localparam logic ReqDispatch = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic out_blocked;
   } ctrl_status_type;

endpackage

>>> rtl/prrs_ifs.sv
// Request and response channel interfaces of the scheduler.
// Depends on prrs_pkg for field widths.
interface prrs_req_if;
   logic                             valid;
   logic                             ready;
   logic                             req_type;
   logic [prrs_pkg::IdWidth-1:0]     job_id;
   logic                             high_priority;
   logic [prrs_pkg::BurstWidth-1:0]  burst;

   modport source (output valid, req_type, job_id, high_priority, burst, input ready);
   modport sink   (input valid, req_type, job_id, high_priority, burst, output ready);
endinterface

interface prrs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               accepted;
   logic                               grant_valid;
   logic [prrs_pkg::IdWidth-1:0]       grant_id;
   logic                               grant_high;
   logic [prrs_pkg::QuantumWidth-1:0]  run_time;
   logic [prrs_pkg::QuantumWidth-1:0]  remaining_after;
   logic                               finished;

   modport source (output valid, accepted, grant_valid, grant_id, grant_high, run_time,
                   remaining_after, finished, input ready);
   modport sink   (input valid, accepted, grant_valid, grant_id, grant_high, run_time,
                   remaining_after, finished, output ready);
endinterface

>>> rtl/priority_round_robin_scheduler.sv
// Top level of the two-level priority round-robin quantum scheduler.
// Depends on prrs_pkg, prrs_ifs (channel interfaces), prrs_ctrl, prrs_dp.
//
//   channel   dir   handshake               payload
//   req_chan  in    valid/ready             req_type, job_id, high_priority, burst
//   rsp_chan  out   valid/ready             accepted, grant_*, run_time, ...
//   csr_*     in    APB write/read, pready=1  quantum at byte address 0
//
// For each item, the accept cycle reads both queue heads from RAM; the EXEC state then
// updates the queues and loads the result register once the result register is free.
// While a result waits unread, the next item is accepted but its update stalls.
// Reset is synchronous; queue entries need no clearing.
module priority_round_robin_scheduler #(
   parameter int QUEUE_DEPTH = 8,
   parameter int BURST_BITS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   prrs_req_if.sink                             req_chan,
   prrs_rsp_if.source                           rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [prrs_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [prrs_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [prrs_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   prrs_pkg::ctrl_cmd_type    ctrl_cmd;
   prrs_pkg::ctrl_status_type ctrl_status;

   logic [prrs_pkg::QuantumWidth-1:0] quantum_ff, quantum_in;
   logic                              csr_wr;

   assign csr_wr = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == prrs_pkg::RegQuantum);
   assign quantum_in = csr_wr ? csr_pwdata[prrs_pkg::QuantumWidth-1:0] : quantum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= prrs_pkg::QuantumReset;
      end else begin
         quantum_ff <= quantum_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == prrs_pkg::RegQuantum)
                       ? prrs_pkg::CsrDataWidth'(quantum_ff) : '0;

   prrs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (ctrl_status),
      .cmd    (ctrl_cmd)
   );

   assign req_chan.ready = ctrl_cmd.req_ready;

   prrs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .BURST_BITS(BURST_BITS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (ctrl_cmd),
      .status              (ctrl_status),
      .req_valid           (req_chan.valid),
      .req_type            (req_chan.req_type),
      .job_id              (req_chan.job_id),
      .high_priority       (req_chan.high_priority),
      .burst               (req_chan.burst),
      .quantum             (quantum_ff),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_accepted        (rsp_chan.accepted),
      .rsp_grant_valid     (rsp_chan.grant_valid),
      .rsp_grant_id        (rsp_chan.grant_id),
      .rsp_grant_high      (rsp_chan.grant_high),
      .rsp_run_time        (rsp_chan.run_time),
      .rsp_remaining_after (rsp_chan.remaining_after),
      .rsp_finished        (rsp_chan.finished)
   );

endmodule

>>> rtl/prrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prrs_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/prrs_ctrl.sv
// Scheduler controller: accept an item, then commit it once the result register is free.
// Depends on prrs_pkg.
module prrs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  prrs_pkg::ctrl_status_type status,
   output prrs_pkg::ctrl_cmd_type    cmd
);

   prrs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prrs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prrs_pkg::ST_IDLE: begin
            if (status.req_valid) begin
               state_in = prrs_pkg::ST_EXEC;
            end
         end
         prrs_pkg::ST_EXEC: begin
            if (!status.out_blocked) begin
               state_in = prrs_pkg::ST_IDLE;
            end
         end
         default: state_in = prrs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         prrs_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.capture   = status.req_valid;
         end
         prrs_pkg::ST_EXEC: begin
            cmd.commit = !status.out_blocked;
         end
         default: cmd = '0;
      endcase
   end

endmodule

>>> rtl/prrs_dp.sv
// Scheduler datapath: two ring queues in RAM, pointers, counts, slice math, result register.
// Depends on prrs_pkg and prrs_ram.
module prrs_dp #(
   parameter int QUEUE_DEPTH = 8,
   parameter int BURST_BITS  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  prrs_pkg::ctrl_cmd_type              cmd,
   output prrs_pkg::ctrl_status_type           status,
   input  logic                                req_valid,
   input  logic                                req_type,
   input  logic [prrs_pkg::IdWidth-1:0]        job_id,
   input  logic                                high_priority,
   input  logic [prrs_pkg::BurstWidth-1:0]     burst,
   input  logic [prrs_pkg::QuantumWidth-1:0]   quantum,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_accepted,
   output logic                                rsp_grant_valid,
   output logic [prrs_pkg::IdWidth-1:0]        rsp_grant_id,
   output logic                                rsp_grant_high,
   output logic [prrs_pkg::QuantumWidth-1:0]   rsp_run_time,
   output logic [prrs_pkg::QuantumWidth-1:0]   rsp_remaining_after,
   output logic                                rsp_finished
);

   localparam int PtrWidth   = $clog2(QUEUE_DEPTH);
   localparam int CntWidth   = $clog2(QUEUE_DEPTH + 1);
   localparam int RemWidth   = (BURST_BITS < prrs_pkg::BurstWidth) ? BURST_BITS
                                                                    : prrs_pkg::BurstWidth;
   localparam int EntryWidth = prrs_pkg::IdWidth + RemWidth;
   localparam int QW         = prrs_pkg::QuantumWidth;
   localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt  = CntWidth'(QUEUE_DEPTH);

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] p);
      next_ptr = (p == LastPtr) ? '0 : p + PtrWidth'(1);
   endfunction

   // captured item
   logic                         item_dispatch_ff;
   logic [prrs_pkg::IdWidth-1:0] item_id_ff;
   logic                         item_high_ff;
   logic [RemWidth-1:0]          item_rem_ff;

   logic [PtrWidth-1:0] hi_head_ff, hi_head_in, hi_tail_ff, hi_tail_in;
   logic [PtrWidth-1:0] nm_head_ff, nm_head_in, nm_tail_ff, nm_tail_in;
   logic [CntWidth-1:0] job_count_ff, job_count_in, high_count_ff, high_count_in;

   logic [EntryWidth-1:0] hi_rdata, nm_rdata, head_entry, push_entry;
   logic [prrs_pkg::IdWidth-1:0] head_id;
   logic [QW-1:0] head_rem, slice, rest;
   logic queue_empty, queue_full, pick_high;
   logic do_pop, pop_high, do_push, push_high, requeue, hi_wr, nm_wr;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_accepted_ff, rsp_grant_valid_ff, rsp_grant_high_ff;
   logic                         rsp_finished_ff;
   logic [prrs_pkg::IdWidth-1:0] rsp_grant_id_ff;
   logic [QW-1:0]                rsp_run_time_ff, rsp_remaining_ff;

   prrs_ram #(.WIDTH(EntryWidth), .DEPTH(QUEUE_DEPTH)) u_high_q (
      .clock   (clock),
      .wr_en   (hi_wr),
      .wr_addr (hi_tail_ff),
      .wr_data (push_entry),
      .rd_en   (cmd.capture),
      .rd_addr (hi_head_ff),
      .rd_data (hi_rdata)
   );

   prrs_ram #(.WIDTH(EntryWidth), .DEPTH(QUEUE_DEPTH)) u_normal_q (
      .clock   (clock),
      .wr_en   (nm_wr),
      .wr_addr (nm_tail_ff),
      .wr_data (push_entry),
      .rd_en   (cmd.capture),
      .rd_addr (nm_head_ff),
      .rd_data (nm_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_dispatch_ff <= (req_type == prrs_pkg::ReqDispatch);
         item_id_ff       <= job_id;
         item_high_ff     <= high_priority;
         item_rem_ff      <= burst[RemWidth-1:0];
      end
   end

   always_comb begin
      queue_empty = (job_count_ff == '0);
      queue_full  = (job_count_ff == FullCnt);
      pick_high   = (high_count_ff != '0);
      head_entry  = pick_high ? hi_rdata : nm_rdata;
      head_id     = head_entry[EntryWidth-1 -: prrs_pkg::IdWidth];
      head_rem    = QW'(head_entry[RemWidth-1:0]);
      slice       = (head_rem > quantum) ? quantum : head_rem;
      rest        = head_rem - slice;

      do_pop    = item_dispatch_ff && !queue_empty;
      pop_high  = do_pop && pick_high;
      requeue   = do_pop && (rest != '0);
      do_push   = requeue || (!item_dispatch_ff && !queue_full);
      push_high = item_dispatch_ff ? pick_high : item_high_ff;
      push_entry = item_dispatch_ff ? {head_id, rest[RemWidth-1:0]}
                                    : {item_id_ff, item_rem_ff};
      hi_wr = cmd.commit && do_push && push_high;
      nm_wr = cmd.commit && do_push && !push_high;

      hi_head_in = hi_head_ff;
      nm_head_in = nm_head_ff;
      hi_tail_in = hi_wr ? next_ptr(hi_tail_ff) : hi_tail_ff;
      nm_tail_in = nm_wr ? next_ptr(nm_tail_ff) : nm_tail_ff;
      job_count_in  = job_count_ff;
      high_count_in = high_count_ff;
      if (cmd.commit) begin
         if (pop_high) begin
            hi_head_in = next_ptr(hi_head_ff);
         end
         if (do_pop && !pick_high) begin
            nm_head_in = next_ptr(nm_head_ff);
         end
         job_count_in  = job_count_ff + CntWidth'(do_push) - CntWidth'(do_pop);
         high_count_in = high_count_ff + CntWidth'(do_push && push_high)
                         - CntWidth'(pop_high);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_head_ff    <= '0;
         hi_tail_ff    <= '0;
         nm_head_ff    <= '0;
         nm_tail_ff    <= '0;
         job_count_ff  <= '0;
         high_count_ff <= '0;
      end else begin
         hi_head_ff    <= hi_head_in;
         hi_tail_ff    <= hi_tail_in;
         nm_head_ff    <= nm_head_in;
         nm_tail_ff    <= nm_tail_in;
         job_count_ff  <= job_count_in;
         high_count_ff <= high_count_in;
      end
   end

   // result register
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_accepted_ff    <= !item_dispatch_ff && !queue_full;
         rsp_grant_valid_ff <= do_pop;
         rsp_grant_id_ff    <= do_pop ? head_id : '0;
         rsp_grant_high_ff  <= pop_high;
         rsp_run_time_ff    <= do_pop ? slice : '0;
         rsp_remaining_ff   <= do_pop ? rest : '0;
         rsp_finished_ff    <= do_pop && (rest == '0);
      end
   end

   assign status.req_valid   = req_valid;
   assign status.out_blocked = rsp_valid_ff && !rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_accepted_ff;
   assign rsp_grant_valid     = rsp_grant_valid_ff;
   assign rsp_grant_id        = rsp_grant_id_ff;
   assign rsp_grant_high      = rsp_grant_high_ff;
   assign rsp_run_time        = rsp_run_time_ff;
   assign rsp_remaining_after = rsp_remaining_ff;
   assign rsp_finished        = rsp_finished_ff;

endmodule

>>> rtl/prrs_checker.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on prrs_pkg and priority_round_robin_scheduler.
module prrs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_accepted,
   input logic                                rsp_grant_valid,
   input logic [prrs_pkg::IdWidth-1:0]        rsp_grant_id,
   input logic [prrs_pkg::QuantumWidth-1:0]   rsp_run_time,
   input logic [prrs_pkg::QuantumWidth-1:0]   rsp_remaining_after,
   input logic                                rsp_finished,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [prrs_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input logic [prrs_pkg::CsrDataWidth-1:0]   csr_pwdata,
   input logic [prrs_pkg::CsrDataWidth-1:0]   csr_prdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_grant_id) && $stable(rsp_run_time)
                                  && $stable(rsp_remaining_after))
      else $error("result changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in work");

   a_grant_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grant_valid |-> !rsp_accepted
                                       && (rsp_finished == (rsp_remaining_after == '0)))
      else $error("grant fields inconsistent");

   a_quantum_write: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == prrs_pkg::RegQuantum)
      |=> csr_prdata[prrs_pkg::QuantumWidth-1:0]
          == $past(csr_pwdata[prrs_pkg::QuantumWidth-1:0]) || csr_paddr[2] != 1'b0)
      else $error("quantum readback mismatch");

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_accepted        (rsp_chan.accepted),
   .rsp_grant_valid     (rsp_chan.grant_valid),
   .rsp_grant_id        (rsp_chan.grant_id),
   .rsp_run_time        (rsp_chan.run_time),
   .rsp_remaining_after (rsp_chan.remaining_after),
   .rsp_finished        (rsp_chan.finished),
   .csr_psel            (csr_psel),
   .csr_penable         (csr_penable),
   .csr_pwrite          (csr_pwrite),
   .csr_paddr           (csr_paddr),
   .csr_pwdata          (csr_pwdata),
   .csr_prdata          (csr_prdata)
);
